>>> hdl/wrlbt_pkg.sv
// ---------------------------------------------------------------------------
// wrlbt_pkg
// Shared types and constants of the windowed rate limiter with backlog trim.
// ---------------------------------------------------------------------------
package wrlbt_pkg;

    localparam int PAY_W    = 6;
    localparam int CHARGE_W = 12;
    localparam int LIMIT_W  = 20;
    localparam int TICKS_W  = 32;
    localparam int MAXBL_W  = 13;
    localparam int TIME_W   = 48;
    localparam int TOTAL_W  = 32;
    localparam int TRIMC_W  = 13;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [2:0] REG_PAYLOAD  = 3'd0;
    localparam logic [2:0] REG_CHARGE   = 3'd1;
    localparam logic [2:0] REG_LIMIT    = 3'd2;
    localparam logic [2:0] REG_TICKS    = 3'd3;
    localparam logic [2:0] REG_MAX_BL   = 3'd4;

    localparam logic [PAY_W-1:0]    RST_PAYLOAD = 6'd32;
    localparam logic [CHARGE_W-1:0] RST_CHARGE  = 12'd40;
    localparam logic [LIMIT_W-1:0]  RST_LIMIT   = 20'd2000;
    localparam logic [TICKS_W-1:0]  RST_TICKS   = 32'd1000000;
    localparam logic [MAXBL_W-1:0]  RST_MAX_BL  = 13'd1024;

    localparam logic OP_PUSH    = 1'b0;
    localparam logic OP_SERVICE = 1'b1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_TRIM    = 2'd1,
        KIND_PUSH    = 2'd2
    } t_kind;

endpackage

>>> hdl/wrlbt_in_if.sv
// ---------------------------------------------------------------------------
// wrlbt_in_if
// Input word channel: push byte or service time.
// ---------------------------------------------------------------------------
interface wrlbt_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  data_byte;
    logic [47:0] now_time;

    modport source (output valid, op, data_byte, now_time, input ready);
    modport sink   (input valid, op, data_byte, now_time, output ready);
endinterface

>>> hdl/wrlbt_out_if.sv
// ---------------------------------------------------------------------------
// wrlbt_out_if
// Result word channel: payload bytes, trim reports and push status.
// ---------------------------------------------------------------------------
interface wrlbt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [31:0] sequence_id;
    logic        last_of_packet;
    logic [12:0] trim_count;
    logic [31:0] dropped_total;
    logic [31:0] trim_events;
    logic        overflow;
    logic        last;

    modport source (output valid, kind, byte_value, sequence_id, last_of_packet, trim_count,
                    dropped_total, trim_events, overflow, last, input ready);
    modport sink   (input valid, kind, byte_value, sequence_id, last_of_packet, trim_count,
                    dropped_total, trim_events, overflow, last, output ready);
endinterface

>>> hdl/windowed_rate_limiter_backlog_trim_core.sv
// ---------------------------------------------------------------------------
// windowed_rate_limiter_backlog_trim_core
// Byte backlog FIFO with sliding-window packet release and backlog trimming.
// ---------------------------------------------------------------------------
// A push word gives one status word; pushes run one per cycle while the result
// side keeps up and no service word is in progress. A service word works on one
// item at a time through single-port reads of the window record memory and the
// backlog memory: first the expired window records, then the released payload
// bytes, then the bytes of the start-code scan; it waits whenever the result side
// stalls. The output register holds one result while the next is prepared.
// No clearing pass is needed after reset.
module windowed_rate_limiter_backlog_trim_core
    import wrlbt_pkg::*;
#(
    parameter int BACKLOG_DEPTH  = 4096,
    parameter int WINDOW_RECORDS = 64,
    parameter int MAX_PAYLOAD    = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    wrlbt_in_if.sink            i_in_ch,
    wrlbt_out_if.source         o_out_ch,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [ADDR_W-1:0]   i_paddr,
    input  logic [DATA_W-1:0]   i_pwdata,
    output logic [DATA_W-1:0]   o_prdata,
    output logic                o_pready
);

    localparam int BL_AW = $clog2(BACKLOG_DEPTH);
    localparam int BL_OW = BL_AW + 1;
    localparam int WR_AW = $clog2(WINDOW_RECORDS);
    localparam int WR_OW = WR_AW + 1;
    localparam int CMPW  = (BL_OW > MAXBL_W) ? BL_OW : MAXBL_W;
    localparam int WM_W  = TIME_W + CHARGE_W;
    localparam logic [BL_OW-1:0] BL_D  = BL_OW'(BACKLOG_DEPTH);
    localparam logic [WR_OW-1:0] WR_D  = WR_OW'(WINDOW_RECORDS);
    localparam logic [PAY_W-1:0] PAY_M = PAY_W'(MAX_PAYLOAD);

    typedef enum logic [3:0] {
        S_IDLE, S_EXP_RD, S_EXP_CHK, S_REL_CHK, S_REL_RD, S_REL_EMIT,
        S_TRIM_RD, S_TRIM_CHK, S_TRIM_EMIT
    } t_state;

    function automatic logic [BL_AW-1:0] bl_wrap(input logic [BL_AW-1:0] head,
                                                 input logic [BL_OW-1:0] off);
        logic [BL_OW-1:0] sum;
        sum = {1'b0, head} + off;
        if (sum >= BL_D) begin
            sum = sum - BL_D;
        end
        return sum[BL_AW-1:0];
    endfunction

    function automatic logic [WR_AW-1:0] wr_wrap(input logic [WR_AW-1:0] head,
                                                 input logic [WR_OW-1:0] off);
        logic [WR_OW-1:0] sum;
        sum = {1'b0, head} + off;
        if (sum >= WR_D) begin
            sum = sum - WR_D;
        end
        return sum[WR_AW-1:0];
    endfunction

    // configuration
    logic [PAY_W-1:0]    r_payload;
    logic [CHARGE_W-1:0] r_charge;
    logic [LIMIT_W-1:0]  r_limit;
    logic [TICKS_W-1:0]  r_ticks;
    logic [MAXBL_W-1:0]  r_max_bl;

    // state
    t_state              r_state;
    logic [BL_AW-1:0]    r_bl_head;
    logic [BL_OW-1:0]    r_bl_count;
    logic [WR_AW-1:0]    r_wr_head;
    logic [WR_OW-1:0]    r_wr_entries;
    logic [LIMIT_W-1:0]  r_wr_bytes;
    logic [TOTAL_W-1:0]  r_seq;
    logic [TOTAL_W-1:0]  r_drop_total;
    logic [TOTAL_W-1:0]  r_trim_total;
    logic [TIME_W-1:0]   r_now;
    logic [PAY_W-1:0]    r_pay;
    logic                r_trim_pend;
    logic [BL_OW-1:0]    r_off;
    logic [BL_OW-1:0]    r_target;
    logic [BL_OW-1:0]    r_drop;
    logic [23:0]         r_shift;

    // memories
    logic [7:0]          r_bl_mem [BACKLOG_DEPTH];
    logic [7:0]          r_bl_rdata;
    logic [WM_W-1:0]     r_wr_mem [WINDOW_RECORDS];
    logic [WM_W-1:0]     r_wr_rdata;

    // output register
    logic                r_o_valid;
    t_kind               r_o_kind;
    logic [7:0]          r_o_byte;
    logic [TOTAL_W-1:0]  r_o_seq;
    logic                r_o_lastp;
    logic [TRIMC_W-1:0]  r_o_trimc;
    logic [TOTAL_W-1:0]  r_o_dtot;
    logic [TOTAL_W-1:0]  r_o_tev;
    logic                r_o_ovf;
    logic                r_o_last;

    logic                can_emit;
    logic                in_acc;
    logic                out_load;
    logic                bl_we;
    logic [BL_AW-1:0]    bl_waddr;
    logic                bl_re;
    logic [BL_AW-1:0]    bl_raddr;
    logic                wr_we;
    logic [WR_AW-1:0]    wr_waddr;
    logic                wr_re;
    logic [PAY_W-1:0]    pay_eff;
    logic [CMPW-1:0]     cnt_ext;
    logic [CMPW-1:0]     cnt_after;
    logic [CMPW-1:0]     max_ext;
    logic                rel_ok;
    logic [TIME_W-1:0]   rec_time;
    logic [CHARGE_W-1:0] rec_charge;
    logic                rec_live;
    logic [7:0]          b0, b1, b2, b3;
    logic                sc_hit;
    logic [BL_OW-1:0]    scan_i;
    logic [TOTAL_W:0]    dtot_sum;
    logic [BL_OW-1:0]    dtot_drop;

    assign can_emit = !r_o_valid || o_out_ch.ready;
    assign i_in_ch.ready = (r_state == S_IDLE) && can_emit;
    assign in_acc = i_in_ch.valid && i_in_ch.ready;
    assign out_load = ((r_state == S_IDLE) && in_acc && (i_in_ch.op == OP_PUSH))
                   || (((r_state == S_REL_EMIT) || (r_state == S_TRIM_EMIT)) && can_emit);

    assign pay_eff   = (r_payload > PAY_M) ? PAY_M : r_payload;
    assign cnt_ext   = CMPW'(r_bl_count);
    assign cnt_after = CMPW'(r_bl_count - BL_OW'(r_pay));
    assign max_ext   = CMPW'(r_max_bl);
    assign rel_ok    = (r_pay != '0) && (r_bl_count >= BL_OW'(r_pay))
                    && (r_wr_entries < WR_D)
                    && ((LIMIT_W+1)'(r_wr_bytes) + (LIMIT_W+1)'(r_charge)
                        <= (LIMIT_W+1)'(r_limit));

    assign rec_time   = r_wr_rdata[WM_W-1:CHARGE_W];
    assign rec_charge = r_wr_rdata[CHARGE_W-1:0];
    assign rec_live   = (r_now < rec_time) || ((r_now - rec_time) <= TIME_W'(r_ticks));

    assign b0 = r_shift[23:16];
    assign b1 = r_shift[15:8];
    assign b2 = r_shift[7:0];
    assign b3 = r_bl_rdata;
    assign sc_hit = ((b0 == 8'd0) && (b1 == 8'd0) && (b2 == 8'd1))
                 || ((b0 == 8'd0) && (b1 == 8'd0) && (b2 == 8'd0) && (b3 == 8'd1));
    assign scan_i = r_off - BL_OW'(3);

    assign dtot_drop = r_drop;
    assign dtot_sum  = {1'b0, r_drop_total} + (TOTAL_W+1)'(dtot_drop);

    // memory control
    assign bl_we    = in_acc && (i_in_ch.op == OP_PUSH) && (r_bl_count < BL_D);
    assign bl_waddr = bl_wrap(r_bl_head, r_bl_count);
    assign bl_re    = (r_state == S_REL_RD) || (r_state == S_TRIM_RD);
    assign bl_raddr = bl_wrap(r_bl_head, r_off);
    assign wr_re    = (r_state == S_EXP_RD);
    assign wr_we    = (r_state == S_REL_EMIT) && can_emit
                   && (r_off == BL_OW'(r_pay) - BL_OW'(1));
    assign wr_waddr = wr_wrap(r_wr_head, r_wr_entries);

    always_ff @(posedge i_clk) begin
        if (bl_we) begin
            r_bl_mem[bl_waddr] <= i_in_ch.data_byte;
        end
        if (bl_re) begin
            r_bl_rdata <= r_bl_mem[bl_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_we) begin
            r_wr_mem[wr_waddr] <= {r_now, r_charge};
        end
        if (wr_re) begin
            r_wr_rdata <= r_wr_mem[r_wr_head];
        end
    end

    // configuration port
    assign o_pready = 1'b1;

    always_comb begin
        unique case (i_paddr[4:2])
            REG_PAYLOAD: o_prdata = DATA_W'(r_payload);
            REG_CHARGE:  o_prdata = DATA_W'(r_charge);
            REG_LIMIT:   o_prdata = DATA_W'(r_limit);
            REG_TICKS:   o_prdata = DATA_W'(r_ticks);
            REG_MAX_BL:  o_prdata = DATA_W'(r_max_bl);
            default:     o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload <= RST_PAYLOAD;
            r_charge  <= RST_CHARGE;
            r_limit   <= RST_LIMIT;
            r_ticks   <= RST_TICKS;
            r_max_bl  <= RST_MAX_BL;
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (i_paddr[4:2])
                REG_PAYLOAD: r_payload <= i_pwdata[PAY_W-1:0];
                REG_CHARGE:  r_charge  <= i_pwdata[CHARGE_W-1:0];
                REG_LIMIT:   r_limit   <= i_pwdata[LIMIT_W-1:0];
                REG_TICKS:   r_ticks   <= i_pwdata[TICKS_W-1:0];
                REG_MAX_BL:  r_max_bl  <= i_pwdata[MAXBL_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bl_head    <= '0;
            r_bl_count   <= '0;
            r_wr_head    <= '0;
            r_wr_entries <= '0;
            r_wr_bytes   <= '0;
            r_seq        <= '0;
            r_drop_total <= '0;
            r_trim_total <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_now <= i_in_ch.now_time;
                        r_pay <= pay_eff;
                        if (i_in_ch.op == OP_PUSH) begin
                            if (r_bl_count < BL_D) begin
                                r_bl_count <= r_bl_count + BL_OW'(1);
                            end
                            r_o_kind  <= KIND_PUSH;
                            r_o_byte  <= '0;
                            r_o_seq   <= '0;
                            r_o_lastp <= 1'b0;
                            r_o_trimc <= '0;
                            r_o_dtot  <= '0;
                            r_o_tev   <= '0;
                            r_o_ovf   <= (r_bl_count >= BL_D);
                            r_o_last  <= 1'b1;
                        end else begin
                            r_state <= S_EXP_RD;
                        end
                    end
                end
                S_EXP_RD: begin
                    r_state <= (r_wr_entries != '0) ? S_EXP_CHK : S_REL_CHK;
                end
                S_EXP_CHK: begin
                    if (rec_live) begin
                        r_state <= S_REL_CHK;
                    end else begin
                        r_wr_bytes   <= r_wr_bytes - LIMIT_W'(rec_charge);
                        r_wr_head    <= wr_wrap(r_wr_head, WR_OW'(1));
                        r_wr_entries <= r_wr_entries - WR_OW'(1);
                        r_state      <= S_EXP_RD;
                    end
                end
                S_REL_CHK: begin
                    r_off <= '0;
                    if (r_pay == '0) begin
                        r_state <= S_IDLE;
                    end else if (rel_ok) begin
                        r_trim_pend <= cnt_after > max_ext;
                        r_state     <= S_REL_RD;
                    end else begin
                        r_trim_pend <= cnt_ext > max_ext;
                        r_state     <= S_TRIM_RD;
                    end
                end
                S_REL_RD: begin
                    r_state <= S_REL_EMIT;
                end
                S_REL_EMIT: begin
                    if (can_emit) begin
                        r_o_kind  <= KIND_PAYLOAD;
                        r_o_byte  <= r_bl_rdata;
                        r_o_seq   <= r_seq;
                        r_o_trimc <= '0;
                        r_o_dtot  <= '0;
                        r_o_tev   <= '0;
                        r_o_ovf   <= 1'b0;
                        if (r_off == BL_OW'(r_pay) - BL_OW'(1)) begin
                            r_o_lastp    <= 1'b1;
                            r_o_last     <= !r_trim_pend;
                            r_seq        <= r_seq + TOTAL_W'(1);
                            r_wr_entries <= r_wr_entries + WR_OW'(1);
                            r_wr_bytes   <= r_wr_bytes + LIMIT_W'(r_charge);
                            r_bl_head    <= bl_wrap(r_bl_head, BL_OW'(r_pay));
                            r_bl_count   <= r_bl_count - BL_OW'(r_pay);
                            r_off        <= '0;
                            r_state      <= S_TRIM_RD;
                        end else begin
                            r_o_lastp <= 1'b0;
                            r_o_last  <= 1'b0;
                            r_off     <= r_off + BL_OW'(1);
                            r_state   <= S_REL_RD;
                        end
                    end
                end
                S_TRIM_RD: begin
                    // first visit: set up the scan start
                    if (!r_trim_pend) begin
                        r_state <= S_IDLE;
                    end else if (r_off == '0) begin
                        r_target <= BL_OW'(cnt_ext - max_ext);
                        r_drop   <= BL_OW'(cnt_ext - max_ext);
                        r_off    <= BL_OW'(cnt_ext - max_ext);
                        if (BL_OW'(cnt_ext - max_ext) + BL_OW'(4) >= r_bl_count) begin
                            r_state <= S_TRIM_EMIT;
                        end
                    end else begin
                        r_state <= S_TRIM_CHK;
                    end
                end
                S_TRIM_CHK: begin
                    r_shift <= {r_shift[15:0], r_bl_rdata};
                    if (r_off >= r_target + BL_OW'(3)) begin
                        if (sc_hit) begin
                            r_drop  <= scan_i;
                            r_state <= S_TRIM_EMIT;
                        end else if (r_off + BL_OW'(2) >= r_bl_count) begin
                            r_state <= S_TRIM_EMIT;
                        end else begin
                            r_off   <= r_off + BL_OW'(1);
                            r_state <= S_TRIM_RD;
                        end
                    end else begin
                        r_off   <= r_off + BL_OW'(1);
                        r_state <= S_TRIM_RD;
                    end
                end
                S_TRIM_EMIT: begin
                    if (can_emit) begin
                        r_bl_head  <= bl_wrap(r_bl_head, r_drop);
                        r_bl_count <= r_bl_count - r_drop;
                        if (dtot_sum[TOTAL_W]) begin
                            r_drop_total <= '1;
                            r_o_dtot     <= '1;
                        end else begin
                            r_drop_total <= dtot_sum[TOTAL_W-1:0];
                            r_o_dtot     <= dtot_sum[TOTAL_W-1:0];
                        end
                        if (r_trim_total != '1) begin
                            r_trim_total <= r_trim_total + TOTAL_W'(1);
                            r_o_tev      <= r_trim_total + TOTAL_W'(1);
                        end else begin
                            r_o_tev      <= r_trim_total;
                        end
                        r_o_kind  <= KIND_TRIM;
                        r_o_byte  <= '0;
                        r_o_seq   <= '0;
                        r_o_lastp <= 1'b0;
                        r_o_trimc <= TRIMC_W'(r_drop);
                        r_o_ovf   <= 1'b0;
                        r_o_last  <= 1'b1;
                        r_off     <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_ch.valid          = r_o_valid;
    assign o_out_ch.kind           = r_o_kind;
    assign o_out_ch.byte_value     = r_o_byte;
    assign o_out_ch.sequence_id    = r_o_seq;
    assign o_out_ch.last_of_packet = r_o_lastp;
    assign o_out_ch.trim_count     = r_o_trimc;
    assign o_out_ch.dropped_total  = r_o_dtot;
    assign o_out_ch.trim_events    = r_o_tev;
    assign o_out_ch.overflow       = r_o_ovf;
    assign o_out_ch.last           = r_o_last;

endmodule

>>> dv/windowed_rate_limiter_backlog_trim_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// windowed_rate_limiter_backlog_trim_core_tb
// Drives push and service words through the core over several register
// settings and idle patterns, predicts every result word from a behavioral
// model of the backlog FIFO, sliding window and start-code trim, and checks
// each accepted result word field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module windowed_rate_limiter_backlog_trim_core_tb;
    import wrlbt_pkg::*;

    localparam int BL_DEPTH    = 4096;
    localparam int WIN_RECS    = 64;
    localparam int PAY_MAX     = 48;
    localparam int STALL_LIMIT = 40000;

    typedef struct {
        logic        op;
        logic [7:0]  data;
        logic [47:0] now;
    } in_word_t;

    typedef struct {
        t_kind       kind;
        logic [7:0]  byte_value;
        logic [31:0] seq_id;
        logic        last_of_packet;
        logic [12:0] trim_count;
        logic [31:0] dropped_total;
        logic [31:0] trim_events;
        logic        overflow;
        logic        last;
    } out_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_psel = 1'b0;
    logic i_penable = 1'b0;
    logic i_pwrite = 1'b0;
    logic [ADDR_W-1:0] i_paddr = '0;
    logic [DATA_W-1:0] i_pwdata = '0;
    logic [DATA_W-1:0] o_prdata;
    logic o_pready;

    wrlbt_in_if  in_ch ();
    wrlbt_out_if out_ch ();

    windowed_rate_limiter_backlog_trim_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_ch   (in_ch.sink),
        .o_out_ch  (out_ch.source),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    always #5 i_clk = ~i_clk;

    in_word_t  pending_words[$];
    out_word_t expected_words[$];
    in_word_t  cur_word;
    int        src_idle_pct = 0;
    int        snk_idle_pct = 0;
    int        hold_request = 0;
    int        hold_left = 0;
    int        error_count = 0;
    int        quiet_cycles = 0;
    logic [47:0] clock_ticks = '0;

    // predictor state
    logic [7:0]  bl_mem[BL_DEPTH];
    int          bl_head, bl_count;
    logic [47:0] win_time[WIN_RECS];
    int          win_charge[WIN_RECS];
    int          win_head, win_entries, win_bytes;
    logic [31:0] seq_count, drop_total, trim_total;
    int          cfg_payload = 32, cfg_charge = 40, cfg_limit = 2000, cfg_max_bl = 1024;
    logic [31:0] cfg_ticks = 32'd1000000;

    function automatic void add_expected(t_kind kind, logic [7:0] b, logic [31:0] sq,
                                         logic lp, logic [12:0] tc, logic ovf);
        out_word_t w;
        w.kind = kind;
        w.byte_value = b;
        w.seq_id = sq;
        w.last_of_packet = lp;
        w.trim_count = tc;
        w.dropped_total = (kind == KIND_TRIM) ? drop_total : 32'd0;
        w.trim_events = (kind == KIND_TRIM) ? trim_total : 32'd0;
        w.overflow = ovf;
        w.last = 1'b0;
        expected_words.push_back(w);
    endfunction

    function automatic logic [7:0] bl_at(int off);
        return bl_mem[(bl_head + off) % BL_DEPTH];
    endfunction

    function automatic void predict_word(in_word_t w);
        int prior_size, pay, slot, target, drop_n;
        longint sum;
        logic [47:0] t;
        prior_size = expected_words.size();
        if (w.op == OP_PUSH) begin
            if (bl_count < BL_DEPTH) begin
                bl_mem[(bl_head + bl_count) % BL_DEPTH] = w.data;
                bl_count++;
                add_expected(KIND_PUSH, 0, 0, 0, 0, 1'b0);
            end else begin
                add_expected(KIND_PUSH, 0, 0, 0, 0, 1'b1);
            end
        end else begin
            while (win_entries > 0) begin
                t = win_time[win_head];
                if (w.now < t || (w.now - t) <= {16'd0, cfg_ticks}) break;
                win_bytes -= win_charge[win_head];
                win_head = (win_head + 1) % WIN_RECS;
                win_entries--;
            end
            pay = (cfg_payload > PAY_MAX) ? PAY_MAX : cfg_payload;
            if (pay != 0) begin
                if (bl_count >= pay && win_entries < WIN_RECS &&
                    win_bytes + cfg_charge <= cfg_limit) begin
                    for (int k = 0; k < pay; k++)
                        add_expected(KIND_PAYLOAD, bl_at(k), seq_count, k + 1 == pay, 0, 0);
                    seq_count++;
                    slot = (win_head + win_entries) % WIN_RECS;
                    win_time[slot] = w.now;
                    win_charge[slot] = cfg_charge;
                    win_entries++;
                    win_bytes += cfg_charge;
                    bl_head = (bl_head + pay) % BL_DEPTH;
                    bl_count -= pay;
                end
                if (bl_count > cfg_max_bl) begin
                    target = bl_count - cfg_max_bl;
                    drop_n = target;
                    for (int i = target; i + 4 < bl_count; i++) begin
                        if (bl_at(i) == 0 && bl_at(i + 1) == 0 &&
                            (bl_at(i + 2) == 1 || (bl_at(i + 2) == 0 && bl_at(i + 3) == 1))) begin
                            drop_n = i;
                            break;
                        end
                    end
                    bl_head = (bl_head + drop_n) % BL_DEPTH;
                    bl_count -= drop_n;
                    sum = longint'(drop_total) + drop_n;
                    drop_total = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                    if (trim_total != 32'hFFFF_FFFF) trim_total++;
                    add_expected(KIND_TRIM, 0, 0, 0, drop_n[12:0], 0);
                end
            end
        end
        if (expected_words.size() > prior_size) expected_words[$].last = 1'b1;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        error_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) predict_word(cur_word);
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_word = pending_words[0];
                    pending_words.delete(0);
                    in_ch.op <= cur_word.op;
                    in_ch.data_byte <= cur_word.data;
                    in_ch.now_time <= cur_word.now;
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        out_word_t w;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", 64'(out_ch.kind), 64'd0);
                end else begin
                    w = expected_words[0];
                    expected_words.delete(0);
                    if (out_ch.kind != w.kind)
                        report_mismatch("kind", 64'(out_ch.kind), 64'(w.kind));
                    if (out_ch.byte_value != w.byte_value)
                        report_mismatch("byte_value", 64'(out_ch.byte_value),
                                        64'(w.byte_value));
                    if (out_ch.sequence_id != w.seq_id)
                        report_mismatch("sequence_id", 64'(out_ch.sequence_id),
                                        64'(w.seq_id));
                    if (out_ch.last_of_packet != w.last_of_packet)
                        report_mismatch("last_of_packet", 64'(out_ch.last_of_packet),
                                        64'(w.last_of_packet));
                    if (out_ch.trim_count != w.trim_count)
                        report_mismatch("trim_count", 64'(out_ch.trim_count),
                                        64'(w.trim_count));
                    if (out_ch.dropped_total != w.dropped_total)
                        report_mismatch("dropped_total", 64'(out_ch.dropped_total),
                                        64'(w.dropped_total));
                    if (out_ch.trim_events != w.trim_events)
                        report_mismatch("trim_events", 64'(out_ch.trim_events),
                                        64'(w.trim_events));
                    if (out_ch.overflow != w.overflow)
                        report_mismatch("overflow", 64'(out_ch.overflow), 64'(w.overflow));
                    if (out_ch.last != w.last)
                        report_mismatch("last", 64'(out_ch.last), 64'(w.last));
                end
            end
            if (hold_request > 0 && hold_left == 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n
            || hold_left > 0
            || (pending_words.size() == 0 && expected_words.size() == 0 && !in_ch.valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= {idx, 2'b00};
        i_pwdata <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        case (idx)
            REG_PAYLOAD: cfg_payload = int'(val[5:0]);
            REG_CHARGE:  cfg_charge = int'(val[11:0]);
            REG_LIMIT:   cfg_limit = int'(val[19:0]);
            REG_TICKS:   cfg_ticks = val;
            REG_MAX_BL:  cfg_max_bl = int'(val[12:0]);
            default: ;
        endcase
    endtask

    task automatic set_regs(int pay, int chg, int lim, logic [31:0] tk, int mbl);
        reg_write(REG_PAYLOAD, 32'(pay));
        reg_write(REG_CHARGE, 32'(chg));
        reg_write(REG_LIMIT, 32'(lim));
        reg_write(REG_TICKS, tk);
        reg_write(REG_MAX_BL, 32'(mbl));
    endtask

    task automatic queue_push(logic [7:0] b);
        in_word_t w;
        w.op = OP_PUSH;
        w.data = b;
        w.now = 48'({$urandom, $urandom});
        pending_words.push_back(w);
    endtask

    task automatic queue_service(logic [47:0] t);
        in_word_t w;
        w.op = OP_SERVICE;
        w.data = 8'($urandom);
        w.now = t;
        pending_words.push_back(w);
    endtask

    task automatic queue_random(int n);
        int sel;
        logic [47:0] step;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 70) begin
                sel = $urandom_range(9);
                queue_push(sel < 4 ? 8'h00 : (sel < 6 ? 8'h01 : 8'($urandom)));
            end else begin
                if ($urandom_range(19) == 0) begin
                    clock_ticks = clock_ticks - 48'($urandom_range(1000));
                end else begin
                    step = 48'($urandom_range(3)) * {17'd0, cfg_ticks[31:1]};
                    clock_ticks = clock_ticks + step + 48'($urandom_range(3));
                end
                queue_service(clock_ticks);
            end
        end
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || in_ch.valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.op = OP_PUSH;
        in_ch.data_byte = '0;
        in_ch.now_time = '0;
        out_ch.ready = 1'b0;
        bl_head = 0;
        bl_count = 0;
        win_head = 0;
        win_entries = 0;
        win_bytes = 0;
        seq_count = '0;
        drop_total = '0;
        trim_total = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: release, trim to start code, time wrap and backwards
        set_regs(4, 100, 250, 10, 6);
        queue_push(8'hFF); queue_push(8'h00); queue_push(8'h00); queue_push(8'h01);
        queue_push(8'hAA); queue_push(8'h00); queue_push(8'h00); queue_push(8'h00);
        queue_push(8'h01); queue_push(8'h55); queue_push(8'h12);
        queue_service(48'd0);
        queue_service(48'd5);
        queue_service(48'd5);
        queue_service(48'hFFFF_FFFF_FFFF);
        queue_service(48'd0);
        drain();

        // hold the result side while pushes keep coming
        hold_request = 400;
        for (int i = 0; i < 30; i++) queue_push(8'($urandom));
        queue_random(15);
        drain();

        // zero limit with zero charge
        set_regs(1, 0, 0, 32'hFFFF_FFFF, 4096);
        src_idle_pct = 52;
        for (int i = 0; i < 20; i++) begin
            queue_push(8'($urandom));
            clock_ticks = clock_ticks + 48'd1;
            queue_service(clock_ticks);
        end
        queue_random(8);
        drain();

        set_regs(63, 4095, 1048575, 1, 0);
        src_idle_pct = 0;
        snk_idle_pct = 52;
        queue_random(25);
        drain();

        set_regs(48, 1, 1, 1000, 20);
        src_idle_pct = 16;
        snk_idle_pct = 16;
        queue_random(25);
        drain();

        // release off, then trim everything
        reg_write(REG_PAYLOAD, 32'd0);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        for (int i = 0; i < 6; i++) queue_push(8'($urandom));
        queue_service(clock_ticks);
        drain();
        reg_write(REG_PAYLOAD, 32'd48);
        reg_write(REG_MAX_BL, 32'd0);
        queue_service(clock_ticks + 48'd1);
        drain();

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> windowed_rate_limiter_backlog_trim_core.f
hdl/wrlbt_pkg.sv
hdl/wrlbt_in_if.sv
hdl/wrlbt_out_if.sv
hdl/windowed_rate_limiter_backlog_trim_core.sv
dv/windowed_rate_limiter_backlog_trim_core_tb.sv
